// ===== rtl/sws_pkg.sv =====
// shared types, constants and the sine table builder for the row shift warp
// no dependencies; the rtl files refer to it by scoped names, the bench imports it
`default_nettype none

package sws_pkg;

	// sizes
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_ROWS    = 4096;
	localparam int SINE_STEPS  = 1024;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ADDR_W      = COL_W + 1;
	localparam int STORE_DEPTH = 2 * MAX_WIDTH;
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int SINE_BITS   = $clog2(SINE_STEPS);
	localparam int SINE_W      = 16;
	localparam int PIX_W       = 24;
	localparam int WIDTH_W     = 11;
	localparam int COUNT_W     = 13;
	localparam int AMP_W       = 12;
	localparam int PHASE_W     = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int MOD_W       = COL_W + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd3;

	// opcode of a pixel word (the other code drains)
	localparam logic OP_PIXEL = 1'b0;

	// fixed point constants of the table builder
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic       opcode;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       row_end;
	} result_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] width;
		logic [COUNT_W-1:0] rows;
		logic [AMP_W-1:0]   amplitude;
		logic [PHASE_W-1:0] phase_step;
		logic               changed;
	} cfg_t;

	// one queued word of line store work
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [PIX_W-1:0]  wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              last;
	} op_t;

	typedef struct packed {
		logic             start;
		logic             neg;
		logic [MOD_W-1:0] value;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [COL_W-1:0] rem;
	} mod_rsp_t;

	typedef enum logic [2:0] {
		ST_READY,
		ST_ROM,
		ST_MUL,
		ST_OFF_GO,
		ST_OFF_WAIT,
		ST_RP_GO,
		ST_RP_WAIT
	} front_state_t;

	// q1.15 sine of 2*pi*k/SINE_STEPS, taylor series in q30, first quadrant folded
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
		logic [63:0] th;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] q;
		logic        neg;
		th  = (64'd2 * PI_Q30 * 64'(k)) / 64'(SINE_STEPS);
		neg = 1'b0;
		if (th >= PI_Q30) begin
			neg = 1'b1;
			th  = th - PI_Q30;
		end
		if (th > HALF_PI_Q30) begin
			th = PI_Q30 - th;
		end
		x2 = (th * th) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s  = (th * t) >> 30;
		q  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return neg ? SINE_W'(~q + 64'd1) : SINE_W'(q);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sine_wave_row_shift.sv =====
// top level of the sine wave row shift warp: config registers, front end, queue, back end
// a word that emits a pixel passes the queue, the store read register and the output register
// throughput: one word a cycle while the queue has room; after a row closes the front
// works out the next offset (sine rom, multiply, 11-step remainder), stalling only a row
// that closes before it is ready; after any config write no word is taken until the offset
// and read pointer are redone; reset: control state cleared at once, line store left as is
`default_nettype none

module sine_wave_row_shift (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sws_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire sws_pkg::item_t                  item,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output sws_pkg::result_t                     result
);

	// config registers, raw as written
	logic [sws_pkg::WIDTH_W-1:0] row_width_q;
	logic [sws_pkg::COUNT_W-1:0] row_count_q;
	logic [sws_pkg::AMP_W-1:0]   amplitude_q;
	logic [sws_pkg::PHASE_W-1:0] phase_step_q;

	sws_pkg::cfg_t cfg;
	sws_pkg::op_t  q_data;
	sws_pkg::op_t  q_head;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q  <= sws_pkg::WIDTH_W'(sws_pkg::MAX_WIDTH);
			row_count_q  <= sws_pkg::COUNT_W'(sws_pkg::MAX_ROWS);
			amplitude_q  <= '0;
			phase_step_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sws_pkg::CFG_ROW_WIDTH:  row_width_q  <= cfg_data[sws_pkg::WIDTH_W-1:0];
				sws_pkg::CFG_ROW_COUNT:  row_count_q  <= cfg_data[sws_pkg::COUNT_W-1:0];
				sws_pkg::CFG_AMPLITUDE:  amplitude_q  <= cfg_data[sws_pkg::AMP_W-1:0];
				sws_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data[sws_pkg::PHASE_W-1:0];
				default:                 row_width_q  <= row_width_q;
			endcase
		end
	end

	// width and row count in use: zero acts as one, too large clamps to the maximum
	always_comb begin
		if (row_width_q == '0) begin
			cfg.width = sws_pkg::WIDTH_W'(1);
		end else if (row_width_q > sws_pkg::WIDTH_W'(sws_pkg::MAX_WIDTH)) begin
			cfg.width = sws_pkg::WIDTH_W'(sws_pkg::MAX_WIDTH);
		end else begin
			cfg.width = row_width_q;
		end
		if (row_count_q == '0) begin
			cfg.rows = sws_pkg::COUNT_W'(1);
		end else if (row_count_q > sws_pkg::COUNT_W'(sws_pkg::MAX_ROWS)) begin
			cfg.rows = sws_pkg::COUNT_W'(sws_pkg::MAX_ROWS);
		end else begin
			cfg.rows = row_count_q;
		end
		cfg.amplitude  = amplitude_q;
		cfg.phase_step = phase_step_q;
		// any write restarts the offset and read pointer setup
		cfg.changed    = cfg_we;
	end

	// front: classifies each word, owns column, bank and phase state
	sws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_data)
	);

	// queue: keeps store reads and writes in word order so the sides stall apart
	sws_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// back: line store access and the output register
	sws_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_head_valid),
		.head         (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== rtl/sws_sine_rom.sv =====
// sine table, built at elaboration, with a registered read port
// depends on sws_pkg
`default_nettype none

module sws_sine_rom (
	input  wire logic                         clk,
	input  wire logic [sws_pkg::SINE_BITS-1:0] addr,
	output logic      [sws_pkg::SINE_W-1:0]    data_s1
);

	logic [sws_pkg::SINE_W-1:0] rom_w [sws_pkg::SINE_STEPS];

	for (genvar g = 0; g < sws_pkg::SINE_STEPS; g++) begin : g_entry
		localparam logic [sws_pkg::SINE_W-1:0] ENTRY = sws_pkg::sine_entry(g);
		assign rom_w[g] = ENTRY;
	end

	always_ff @(posedge clk) begin
		data_s1 <= rom_w[addr];
	end

endmodule

`default_nettype wire

// ===== rtl/sws_mod.sv =====
// serial remainder unit: one quotient bit a cycle, result folded to a true modulo
// depends on sws_pkg
`default_nettype none

module sws_mod (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [sws_pkg::WIDTH_W-1:0] divisor,
	input  wire sws_pkg::mod_req_t           req,
	output sws_pkg::mod_rsp_t                rsp
);

	localparam int TRIAL_W = sws_pkg::MOD_W + 1;
	localparam int CNT_W   = $clog2(sws_pkg::MOD_W + 1);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       neg_q;
	logic [sws_pkg::MOD_W-1:0]  val_q;
	logic [sws_pkg::MOD_W-1:0]  rem_q;
	logic [sws_pkg::COL_W-1:0]  res_q;
	logic [TRIAL_W-1:0]         trial;
	logic [TRIAL_W-1:0]         div_ext;
	logic [sws_pkg::MOD_W-1:0]  rem_nx;
	logic [sws_pkg::WIDTH_W-1:0] fold;

	assign trial   = {rem_q, val_q[sws_pkg::MOD_W-1]};
	assign div_ext = TRIAL_W'(divisor);
	assign rem_nx  = (trial >= div_ext) ? sws_pkg::MOD_W'(trial - div_ext)
	                                    : sws_pkg::MOD_W'(trial);
	// negative dividend: nonzero remainder wraps to divisor - r
	assign fold    = (neg_q && (rem_nx != '0))
	                 ? divisor - sws_pkg::WIDTH_W'(rem_nx)
	                 : sws_pkg::WIDTH_W'(rem_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(sws_pkg::MOD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			val_q <= req.value;
			rem_q <= '0;
			neg_q <= req.neg;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			val_q <= val_q << 1;
			if (cnt_q == CNT_W'(1)) begin
				res_q <= fold[sws_pkg::COL_W-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = res_q;

endmodule

`default_nettype wire

// ===== rtl/sws_front.sv =====
// front end: accepts words, tracks columns, banks, rows and phase, precomputes
// the next row offset; depends on sws_pkg, sws_sine_rom and sws_mod
`default_nettype none

module sws_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sws_pkg::cfg_t  cfg,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire sws_pkg::item_t item,
	input  wire logic           q_full,
	output logic                q_push,
	output sws_pkg::op_t        q_data
);

	localparam int NUM_W    = sws_pkg::AMP_W + sws_pkg::SINE_W + 1;
	localparam int DX_SHIFT = 16;
	localparam logic signed [NUM_W-1:0] ROUND_HALF = NUM_W'(1 << (DX_SHIFT - 1));

	logic [sws_pkg::COL_W-1:0]   write_col_q;
	logic [sws_pkg::COL_W-1:0]   read_col_q;
	logic [sws_pkg::COL_W-1:0]   rp_q;
	logic [sws_pkg::COL_W-1:0]   pend_off_q;
	logic [sws_pkg::COL_W-1:0]   off_next_q;
	logic                        write_bank_q;
	logic                        pend_valid_q;
	logic                        rp_redo_q;
	logic [sws_pkg::ROW_W-1:0]   row_idx_q;
	logic [sws_pkg::PHASE_W-1:0] phase_q;
	sws_pkg::front_state_t       state_q;
	sws_pkg::front_state_t       state_nx;

	logic [sws_pkg::SINE_W-1:0]  sine_s1;
	logic signed [NUM_W-1:0]     num_s2;
	logic signed [NUM_W-1:0]     amp_ext;
	logic signed [NUM_W-1:0]     sine_ext;
	logic                        num_neg;
	logic [NUM_W-1:0]            num_mag;
	logic [sws_pkg::MOD_W-1:0]   dx_abs;

	sws_pkg::mod_req_t           mod_req;
	sws_pkg::mod_rsp_t           mod_rsp;

	logic [sws_pkg::WIDTH_W-1:0] wc_inc;
	logic [sws_pkg::WIDTH_W-1:0] rc_inc;
	logic [sws_pkg::WIDTH_W-1:0] rp_inc;
	logic [sws_pkg::COL_W-1:0]   rp_next;
	logic [sws_pkg::COUNT_W-1:0] row_inc;
	logic                        wc_last;
	logic                        rc_last;
	logic                        row_wrap;
	logic                        is_pixel;
	logic                        completes;
	logic                        off_ok;
	logic                        accept;
	logic                        mod_done_off;
	logic                        mod_done_rp;

	sws_sine_rom u_rom (
		.clk     (clk),
		.addr    (phase_q[sws_pkg::PHASE_W-1 -: sws_pkg::SINE_BITS]),
		.data_s1 (sine_s1)
	);

	sws_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.divisor (cfg.width),
		.req     (mod_req),
		.rsp     (mod_rsp)
	);

	// amplitude * sine + half, then truncate toward zero
	assign amp_ext  = NUM_W'($signed(cfg.amplitude));
	assign sine_ext = NUM_W'($signed(sine_s1));

	always_ff @(posedge clk) begin
		num_s2 <= amp_ext * sine_ext + ROUND_HALF;
	end

	assign num_neg = num_s2[NUM_W-1];
	assign num_mag = num_neg ? NUM_W'(-num_s2) : NUM_W'(num_s2);
	assign dx_abs  = num_mag[DX_SHIFT +: sws_pkg::MOD_W];

	assign wc_inc   = sws_pkg::WIDTH_W'(write_col_q) + sws_pkg::WIDTH_W'(1);
	assign rc_inc   = sws_pkg::WIDTH_W'(read_col_q) + sws_pkg::WIDTH_W'(1);
	assign rp_inc   = sws_pkg::WIDTH_W'(rp_q) + sws_pkg::WIDTH_W'(1);
	assign wc_last  = wc_inc >= cfg.width;
	assign rc_last  = rc_inc >= cfg.width;
	assign rp_next  = (rp_inc == cfg.width) ? '0 : rp_inc[sws_pkg::COL_W-1:0];
	assign row_inc  = sws_pkg::COUNT_W'(row_idx_q) + sws_pkg::COUNT_W'(1);
	assign row_wrap = row_inc >= cfg.rows;

	assign is_pixel   = item.opcode == sws_pkg::OP_PIXEL;
	assign completes  = is_pixel && wc_last;
	assign off_ok     = state_q == sws_pkg::ST_READY;
	// a row may close only once its offset is known
	assign item_ready = !q_full && !rp_redo_q && (off_ok || !completes);
	assign accept     = item_valid && item_ready;

	assign mod_done_off = (state_q == sws_pkg::ST_OFF_WAIT) && mod_rsp.done;
	assign mod_done_rp  = (state_q == sws_pkg::ST_RP_WAIT) && mod_rsp.done;

	assign q_push         = accept && (pend_valid_q || is_pixel);
	assign q_data.wr_en   = is_pixel;
	assign q_data.wr_addr = {write_bank_q, write_col_q};
	assign q_data.wr_data = {item.red_in, item.green_in, item.blue_in};
	assign q_data.rd_en   = pend_valid_q;
	assign q_data.rd_addr = {~write_bank_q, rp_q};
	assign q_data.last    = rc_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sws_pkg::ST_ROM;
			write_col_q  <= '0;
			read_col_q   <= '0;
			rp_q         <= '0;
			pend_off_q   <= '0;
			off_next_q   <= '0;
			write_bank_q <= 1'b0;
			pend_valid_q <= 1'b0;
			rp_redo_q    <= 1'b0;
			row_idx_q    <= '0;
			phase_q      <= '0;
		end else begin
			state_q <= state_nx;
			// read side of the word
			if (accept && pend_valid_q) begin
				if (rc_last) begin
					read_col_q   <= '0;
					pend_valid_q <= 1'b0;
				end else begin
					read_col_q <= read_col_q + sws_pkg::COL_W'(1);
					rp_q       <= rp_next;
				end
			end
			// write side; a closing row overrides the read side
			if (accept && is_pixel) begin
				if (wc_last) begin
					pend_off_q   <= off_next_q;
					pend_valid_q <= 1'b1;
					read_col_q   <= '0;
					rp_q         <= off_next_q;
					write_bank_q <= ~write_bank_q;
					write_col_q  <= '0;
					if (row_wrap) begin
						row_idx_q <= '0;
						phase_q   <= '0;
					end else begin
						row_idx_q <= row_inc[sws_pkg::ROW_W-1:0];
						phase_q   <= phase_q + cfg.phase_step;
					end
				end else begin
					write_col_q <= write_col_q + sws_pkg::COL_W'(1);
				end
			end
			if (mod_done_off) begin
				off_next_q <= mod_rsp.rem;
			end
			if (mod_done_rp) begin
				rp_q <= mod_rsp.rem;
			end
			if (cfg.changed) begin
				rp_redo_q <= 1'b1;
			end else if (mod_done_rp) begin
				rp_redo_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			sws_pkg::ST_READY: begin
				if (accept && completes) begin
					state_nx = sws_pkg::ST_ROM;
				end
			end
			sws_pkg::ST_ROM: begin
				state_nx = sws_pkg::ST_MUL;
			end
			sws_pkg::ST_MUL: begin
				state_nx = sws_pkg::ST_OFF_GO;
			end
			sws_pkg::ST_OFF_GO: begin
				state_nx = sws_pkg::ST_OFF_WAIT;
			end
			sws_pkg::ST_OFF_WAIT: begin
				if (mod_rsp.done) begin
					state_nx = rp_redo_q ? sws_pkg::ST_RP_GO : sws_pkg::ST_READY;
				end
			end
			sws_pkg::ST_RP_GO: begin
				state_nx = sws_pkg::ST_RP_WAIT;
			end
			sws_pkg::ST_RP_WAIT: begin
				if (mod_rsp.done) begin
					state_nx = sws_pkg::ST_READY;
				end
			end
			default: begin
				state_nx = sws_pkg::ST_ROM;
			end
		endcase
		if (cfg.changed) begin
			state_nx = sws_pkg::ST_ROM;
		end
	end

	always_comb begin
		mod_req = '0;
		case (state_q)
			sws_pkg::ST_OFF_GO: begin
				mod_req.start = 1'b1;
				mod_req.neg   = num_neg;
				mod_req.value = dx_abs;
			end
			sws_pkg::ST_RP_GO: begin
				mod_req.start = 1'b1;
				mod_req.neg   = 1'b0;
				mod_req.value = sws_pkg::MOD_W'(read_col_q) + sws_pkg::MOD_W'(pend_off_q);
			end
			default: begin
				mod_req = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/sws_fifo.sv =====
// short queue of line store work between front and back end
// depends on sws_pkg
`default_nettype none

module sws_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire sws_pkg::op_t push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              head_valid,
	output sws_pkg::op_t      head
);

	sws_pkg::op_t                entry_q [sws_pkg::QUEUE_DEPTH];
	logic [sws_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [sws_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [sws_pkg::QPTR_W:0]    count_q;

	assign full       = count_q == (sws_pkg::QPTR_W + 1)'(sws_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + sws_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sws_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (sws_pkg::QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (sws_pkg::QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sws_back.sv =====
// back end: two-bank line store, registered read and output register
// depends on sws_pkg
`default_nettype none

module sws_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         head_valid,
	input  wire sws_pkg::op_t head,
	output logic              pop,
	output logic              result_valid,
	input  wire logic         result_ready,
	output sws_pkg::result_t  result
);

	logic [sws_pkg::PIX_W-1:0] store_mem [sws_pkg::STORE_DEPTH];
	logic [sws_pkg::PIX_W-1:0] pix_s1;
	logic                      last_s1;
	logic                      valid_s1;
	sws_pkg::result_t          result_q;
	logic                      result_valid_q;
	logic                      out_free;
	logic                      adv;
	logic                      s1_free;

	assign out_free = !result_valid_q || result_ready;
	assign adv      = valid_s1 && out_free;
	assign s1_free  = !valid_s1 || adv;
	// words with a read wait for room in the read stage; writes alone go at once
	assign pop      = head_valid && (!head.rd_en || s1_free);

	always_ff @(posedge clk) begin
		if (pop && head.wr_en) begin
			store_mem[head.wr_addr] <= head.wr_data;
		end
		if (pop && head.rd_en) begin
			pix_s1  <= store_mem[head.rd_addr];
			last_s1 <= head.last;
		end
		if (adv) begin
			result_q.red_out   <= pix_s1[23:16];
			result_q.green_out <= pix_s1[15:8];
			result_q.blue_out  <= pix_s1[7:0];
			result_q.row_end   <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop && head.rd_en) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// self-checking bench for sine_wave_row_shift: random pixel and drain words in,
// shifted rows predicted and compared field by field by a small scoreboard class
// depends on rtl/sws_pkg.sv (ports, register indexes, opcode) and the top level

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sws_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int LINE_MAX      = 1024;
	localparam int ROWS_MAX      = 4096;
	localparam int WAVE_STEPS    = 1024;
	localparam int ITEM_GOAL     = 2000;
	localparam int TAIL_CYCLES   = 40;     // offset pass after a row closes plus pipeline
	localparam int SQUEEZE_AFTER = 400;    // results seen before the long hold-off
	localparam int SQUEEZE_LEN   = 600;
	localparam int STALL_LIMIT   = 5000;   // quiet cycles before the run is declared hung
	localparam logic OP_DRAIN    = ~OP_PIXEL;

	// angle constants of the sine table, q30
	localparam longint unsigned UNIT_Q30         = 64'd1 << 30;
	localparam longint unsigned HALF_TURN_Q30    = 64'd3373259426;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

	// expected shifted pixels; holds its own copy of the line store, counters and registers
	class row_warp_sb;
		logic [23:0]        store [2*LINE_MAX];
		logic signed [15:0] sine_rom [WAVE_STEPS];
		int unsigned        wr_col, rd_col, row_no, row_off;
		bit                 bank, row_ready;
		logic [23:0]        phase;
		logic [10:0]        width_reg;
		logic [12:0]        count_reg;
		logic signed [11:0] amp_reg;
		logic [23:0]        step_reg;
		result_t            pixels_due [$];
		int unsigned        checked, errors;

		function new();
			for (int k = 0; k < WAVE_STEPS; k++) begin
				sine_rom[k] = taylor_sine(k);
			end
			wr_col    = 0;
			rd_col    = 0;
			row_no    = 0;
			row_off   = 0;
			bank      = 1'b0;
			row_ready = 1'b0;
			phase     = '0;
			width_reg = 11'd1024;
			count_reg = 13'd4096;
			amp_reg   = '0;
			step_reg  = '0;
			checked   = 0;
			errors    = 0;
		endfunction

		// sin(2*pi*k/steps) in q1.15: fold to the first quadrant, horner taylor to x^13
		function automatic logic signed [15:0] taylor_sine(int unsigned k);
			longint unsigned ang, sq, poly, mag, q;
			bit lower;
			ang   = (64'd2 * HALF_TURN_Q30 * k) / WAVE_STEPS;
			lower = 1'b0;
			if (ang >= HALF_TURN_Q30) begin
				lower = 1'b1;
				ang   = ang - HALF_TURN_Q30;
			end
			if (ang > QUARTER_TURN_Q30) begin
				ang = HALF_TURN_Q30 - ang;
			end
			sq   = (ang * ang) >> 30;
			poly = UNIT_Q30;
			// divisors (2j)(2j+1): 156, 110, 72, 42, 20, 6
			for (int j = 6; j >= 1; j--) begin
				poly = UNIT_Q30 - ((sq * poly) >> 30) / longint'((2 * j) * (2 * j + 1));
			end
			mag = (ang * poly) >> 30;
			q   = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
			if (q > 64'd32767) begin
				q = 64'd32767;
			end
			return lower ? 16'(-int'(q)) : 16'(q);
		endfunction

		function int unsigned span_of(logic [10:0] raw);
			if (raw == 0) return 1;
			if (raw > LINE_MAX) return LINE_MAX;
			return raw;
		endfunction

		function int unsigned live_width();
			return span_of(width_reg);
		endfunction

		function int unsigned live_rows();
			if (count_reg == 0) return 1;
			if (count_reg > ROWS_MAX) return ROWS_MAX;
			return count_reg;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_ROW_WIDTH:  width_reg = data[10:0];
				CFG_ROW_COUNT:  count_reg = data[12:0];
				CFG_AMPLITUDE:  amp_reg   = data[11:0];
				CFG_PHASE_STEP: step_reg  = data[23:0];
			endcase
		endfunction

		// one accepted word: emit from the pending row first, then store the pixel
		function void take_word(item_t w);
			int unsigned span, src;
			logic [23:0] px;
			result_t     out;
			longint      lean, shift;
			span = live_width();
			if (row_ready) begin
				src = (rd_col + row_off) % span;
				px  = store[(bank ? 0 : LINE_MAX) + src];
				out.red_out   = px[23:16];
				out.green_out = px[15:8];
				out.blue_out  = px[7:0];
				out.row_end   = (rd_col + 1 >= span);
				pixels_due.push_back(out);
				if (out.row_end) begin
					rd_col    = 0;
					row_ready = 1'b0;
				end else begin
					rd_col++;
				end
			end
			if (w.opcode == OP_PIXEL) begin
				store[(bank ? LINE_MAX : 0) + wr_col] = {w.red_in, w.green_in, w.blue_in};
				if (wr_col + 1 >= span) begin
					// row closed: offset from the current phase, rounded half up, truncated
					lean  = 64'sd32768 + longint'(amp_reg)
						* longint'(sine_rom[(longint'(phase) * WAVE_STEPS) >> 24]);
					shift = lean / 65536;
					shift = shift % longint'(span);
					if (shift < 0) begin
						shift = shift + span;
					end
					row_off   = shift;
					row_ready = 1'b1;
					rd_col    = 0;
					bank      = ~bank;
					wr_col    = 0;
					phase     = phase + step_reg;
					row_no++;
					if (row_no >= live_rows()) begin
						row_no = 0;
						phase  = '0;
					end
				end else begin
					wr_col++;
				end
			end
		endfunction

		function void compare(string what, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
			end
		endfunction

		function void check_pixel(result_t got);
			result_t want;
			if (pixels_due.size() == 0) begin
				errors++;
				$display("%0t ns: pixel %h arrived with nothing expected", $time, got);
				return;
			end
			want = pixels_due.pop_front();
			checked++;
			compare("red", want.red_out, got.red_out);
			compare("green", want.green_out, got.green_out);
			compare("blue", want.blue_out, got.blue_out);
			compare("row_end", 8'(want.row_end), 8'(got.row_end));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  item_valid;
	logic                  item_ready;
	item_t                 item;
	logic                  result_valid;
	logic                  result_ready;
	result_t               result;

	row_warp_sb sb = new();

	int unsigned pixel_words = 0;
	int unsigned drain_words = 0;
	int unsigned settings    = 0;
	bit          steady_feed = 1'b0;   // sender never idles while set

	sine_wave_row_shift u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// idle stretch: mostly a few cycles, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// offer one word, holding it until the block takes it
	task automatic feed(input logic op, input logic [23:0] rgb);
		item_t w;
		int    gap;
		w.opcode = op;
		{w.red_in, w.green_in, w.blue_in} = rgb;
		gap = (steady_feed || $urandom_range(0, 2) != 0) ? 0 : idle_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		sb.take_word(w);
		if (op == OP_PIXEL) pixel_words++;
		else drain_words++;
	endtask

	// stop offering, wait for every expected pixel, then let the offset pass finish
	task automatic settle();
		item_valid <= 1'b0;
		do @(posedge clk); while (sb.pixels_due.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic reconfigure(input logic [10:0] w, input logic [12:0] c,
			input logic [11:0] a, input logic [23:0] s);
		// a wider row would reach store columns the pending row never wrote, so flush it first
		if (sb.span_of(w) > sb.live_width()) begin
			while (sb.row_ready) feed(OP_DRAIN, $urandom);
		end
		settle();
		put_reg(CFG_ROW_WIDTH, 24'(w));
		put_reg(CFG_ROW_COUNT, 24'(c));
		put_reg(CFG_AMPLITUDE, 24'(a));
		put_reg(CFG_PHASE_STEP, s);
		cfg_we <= 1'b0;
		settings++;
	endtask

	// main stimulus
	initial begin
		logic [10:0] w;
		logic [12:0] c;
		logic [23:0] s;
		int          r;
		int          n;
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_ROW_WIDTH;
		cfg_data   <= '0;
		item_valid <= 1'b0;
		item       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// tiny rows, two rows per frame, amplitude one below the largest positive
		reconfigure(11'd4, 13'd2, 12'h7fe, 24'h400000);
		feed(OP_DRAIN, 24'h000000);          // drain with no row pending
		feed(OP_PIXEL, 24'h000000);          // pixel with no row pending
		feed(OP_PIXEL, 24'hffffff);
		feed(OP_PIXEL, 24'hff0000);
		feed(OP_PIXEL, 24'h00ff00);
		feed(OP_PIXEL, 24'h0000ff);
		feed(OP_PIXEL, 24'h5a5a5a);
		feed(OP_PIXEL, 24'ha5a5a5);
		feed(OP_PIXEL, 24'h123456);
		repeat (4) feed(OP_DRAIN, 24'hffffff);

		// zero width and zero rows act as one; most negative amplitude, phase step all ones
		reconfigure(11'd0, 13'd0, 12'h800, 24'hffffff);
		feed(OP_PIXEL, 24'h800080);
		feed(OP_PIXEL, 24'h7f7f7f);
		feed(OP_DRAIN, 24'h000000);

		// width shrinks in the middle of a row while a rotated row is still going out
		reconfigure(11'd5, 13'd3, 12'h801, 24'h2aaaab);
		repeat (7) feed(OP_PIXEL, $urandom);
		reconfigure(11'd2, 13'd3, 12'h802, 24'h2aaaab);
		repeat (3) feed(OP_PIXEL, $urandom);
		feed(OP_DRAIN, $urandom);

		// one full row at the widest setting, width and rows above their maximum
		reconfigure(11'h7ff, 13'h1fff, 12'h7ff, 24'h800000);
		repeat (LINE_MAX) feed(OP_PIXEL, $urandom);
		while (sb.row_ready) feed(OP_DRAIN, $urandom);

		// random settings, mostly short rows, with random pixel content and a few drains
		while (pixel_words < ITEM_GOAL) begin
			r = $urandom_range(0, 9);
			if (r == 0) w = $urandom_range(0, 2047);
			else if (r < 3) w = $urandom_range(17, 128);
			else w = $urandom_range(1, 16);
			r = $urandom_range(0, 9);
			if (r == 0) c = 13'd0;
			else if (r == 1) c = 13'h1fff;
			else if (r == 2) c = $urandom_range(0, 8191);
			else c = $urandom_range(1, 6);
			r = $urandom_range(0, 9);
			if (r == 0) s = '0;
			else if (r == 1) s = $urandom_range(0, 24'hffffff);
			else if (r == 2) s = 24'hffffff;
			else s = 24'((32'd1 << 24) / $urandom_range(2, 64));
			steady_feed = ($urandom_range(0, 3) == 0);
			reconfigure(w, c, 12'($urandom_range(0, 4095)), s);
			n = $urandom_range(40, 200);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0) feed(OP_DRAIN, $urandom);
				else feed(OP_PIXEL, $urandom);
			end
		end
		steady_feed = 1'b0;

		settle();
		sb.errors += sb.pixels_due.size();
		$display("sent %0d pixel words and %0d drain words across %0d register settings",
			pixel_words, drain_words, settings);
		$display("compared %0d shifted pixels, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0) begin
			$display("sine_wave_row_shift regression: pass");
		end else begin
			$display("sine_wave_row_shift regression: fail");
		end
		$finish;
	end

	// result side: check every accepted word against the oldest expectation
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			sb.check_pixel(result);
		end
	end

	// result ready: eager and jittery stretches, plus one long hold-off to back the block up
	initial begin
		int hold;
		int mode_left;
		bit eager;
		bit squeezed;
		hold      = 0;
		mode_left = 0;
		eager     = 1'b1;
		squeezed  = 1'b0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!squeezed && sb.checked >= SQUEEZE_AFTER) begin
				squeezed = 1'b1;
				result_ready <= 1'b0;
				repeat (SQUEEZE_LEN) @(posedge clk);
			end
			if (mode_left == 0) begin
				eager     = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(30, 400);
			end
			mode_left--;
			if (hold == 0 && !eager && $urandom_range(0, 3) == 0) begin
				hold = idle_len();
			end
			if (hold > 0) begin
				hold--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// hang detector: nothing moving on either side for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
			else quiet++;
		end
		$display("%0t ns: no word moved for %0d cycles", $time, quiet);
		$display("sine_wave_row_shift regression: fail");
		$finish;
	end

endmodule

// ===== sine_wave_row_shift.f =====
rtl/sws_pkg.sv
rtl/sws_sine_rom.sv
rtl/sws_mod.sv
rtl/sws_front.sv
rtl/sws_fifo.sv
rtl/sws_back.sv
rtl/sine_wave_row_shift.sv
sim/tb.sv
